// ----- rtl/core/mmpc_pkg.sv -----
// shared constants, types and modular helpers for the matrix product checksum block
// no dependencies; every other file but mmpc_ram refers to it by scoped names
package mmpc_pkg;

	// largest matrix dimension held in the element stores
	localparam int MAX_DIM = 128;

	localparam int KIND_W  = 2;
	localparam int ROW_W   = 7;
	localparam int COL_W   = 7;
	localparam int VAL_W   = 10;
	localparam int SIZE_W  = 8;
	localparam int RES_W   = 10;

	localparam int SIZE_RESET = 128;

	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int unsigned MODULUS = 997;

	// x mod 997 for x below 2^20: q = (x * 1051) >> 20 is q or q-1
	localparam int PROD_W      = 2 * RES_W;
	localparam int RECIP       = 1051;
	localparam int RECIP_W     = 11;
	localparam int RECIP_SHIFT = 20;
	localparam int QP_W        = PROD_W + RECIP_W;

	// op queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [RES_W-1:0]  value;
	} op_entry_t;

	// one conditional subtract, valid for inputs below twice the modulus
	function automatic logic [RES_W-1:0] reduce_once(input logic [RES_W:0] v);
		logic [RES_W:0] d;
		d = v - (RES_W + 1)'(MODULUS);
		reduce_once = (v >= (RES_W + 1)'(MODULUS)) ? d[RES_W-1:0] : v[RES_W-1:0];
	endfunction

	function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
		input logic [RES_W-1:0] b);
		mod_add = reduce_once({1'b0, a} + {1'b0, b});
	endfunction

endpackage

// ----- rtl/core/mmpc_if.sv -----
// valid/ready channel interfaces: input items, checksum results, size register writes
// depends on mmpc_pkg for field widths
interface mmpc_item_if;
	logic                           valid;
	logic                           ready;
	logic [mmpc_pkg::KIND_W-1:0]    kind;
	logic [mmpc_pkg::ROW_W-1:0]     row_index;
	logic [mmpc_pkg::COL_W-1:0]     col_index;
	logic [mmpc_pkg::VAL_W-1:0]     element_value;

	modport source(output valid, kind, row_index, col_index, element_value, input ready);
	modport sink(input valid, kind, row_index, col_index, element_value, output ready);
endinterface

interface mmpc_result_if;
	logic                          valid;
	logic                          ready;
	logic [mmpc_pkg::RES_W-1:0]    checksum;

	modport source(output valid, checksum, input ready);
	modport sink(input valid, checksum, output ready);
endinterface

interface mmpc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mmpc_pkg::SIZE_W-1:0]   matrix_size;

	modport source(output valid, matrix_size, input ready);
	modport sink(input valid, matrix_size, output ready);
endinterface

// ----- rtl/core/mmpc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module mmpc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16384
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/mmpc_front.sv -----
// front end: accepts input transactions, drops unused kinds and out-of-range loads,
// reduces values, forms store addresses and queues ops for the back end; uses mmpc_pkg
module mmpc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	mmpc_item_if.sink             item,
	output logic                  head_valid,
	output mmpc_pkg::op_entry_t   head,
	input  logic                  pop
);

	mmpc_pkg::op_entry_t entries_q [mmpc_pkg::QDEPTH];
	logic [mmpc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [mmpc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [mmpc_pkg::QCNT_W-1:0] count_q;

	logic                accept;
	logic                keep;
	logic                in_range;
	logic                push;
	mmpc_pkg::op_entry_t new_entry;

	assign item.ready = (count_q != mmpc_pkg::QCNT_W'(mmpc_pkg::QDEPTH));
	assign accept     = item.valid && item.ready;

	assign in_range = (int'(item.row_index) < mmpc_pkg::MAX_DIM)
		&& (int'(item.col_index) < mmpc_pkg::MAX_DIM);

	always_comb begin
		keep             = 1'b0;
		new_entry.op     = mmpc_pkg::OP_LOAD_A;
		new_entry.addr   = mmpc_pkg::ADDR_W'(item.row_index)
			* mmpc_pkg::ADDR_W'(mmpc_pkg::MAX_DIM) + mmpc_pkg::ADDR_W'(item.col_index);
		new_entry.value  = mmpc_pkg::reduce_once(
			(mmpc_pkg::RES_W + 1)'(item.element_value));
		case (item.kind)
			mmpc_pkg::KIND_LOAD_A: begin
				keep         = in_range;
				new_entry.op = mmpc_pkg::OP_LOAD_A;
			end
			mmpc_pkg::KIND_LOAD_B: begin
				keep         = in_range;
				new_entry.op = mmpc_pkg::OP_LOAD_B;
			end
			mmpc_pkg::KIND_COMPUTE: begin
				keep         = 1'b1;
				new_entry.op = mmpc_pkg::OP_COMPUTE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = accept && keep;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mmpc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mmpc_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + mmpc_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - mmpc_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mmpc_pkg::QCNT_W'(mmpc_pkg::QDEPTH))
		else $error("op queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("op queue popped while empty");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == mmpc_pkg::QCNT_W'(mmpc_pkg::QDEPTH))
		|-> wr_ptr_q == rd_ptr_q)
		else $error("op queue pointers disagree with count");

endmodule

// ----- rtl/core/mmpc_back.sv -----
// back end: executes queued loads into the A and B stores and walks the stores for a
// compute, accumulating column sums of A and row sums of B; uses mmpc_pkg, mmpc_ram
module mmpc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mmpc_pkg::SIZE_W-1:0] matrix_size,
	input  logic                       head_valid,
	input  mmpc_pkg::op_entry_t        head,
	output logic                       pop,
	mmpc_result_if.source              result
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_DRAIN = 3'b100
	} back_state_t;

	back_state_t state_q, state_d;

	logic [mmpc_pkg::DIM_W-1:0]  dim;
	logic [mmpc_pkg::IDX_W-1:0]  dim_m1;
	logic [mmpc_pkg::IDX_W-1:0]  t_q, k_q;
	logic                        last_t, last_issue;
	logic                        we_a, we_b, walk_re, start, zero_result;
	logic [mmpc_pkg::ADDR_W-1:0] addr_a, addr_b;
	logic [mmpc_pkg::RES_W-1:0]  a_rdata, b_rdata;

	// read return stage
	logic                        rd_v_s1, rd_first_s1, rd_lastt_s1, rd_last_s1;
	logic [mmpc_pkg::RES_W-1:0]  col_acc_q, row_acc_q;
	logic [mmpc_pkg::RES_W-1:0]  col_next, row_next;

	// product and reduction stages
	logic                        v_s2, last_s2, v_s3, last_s3, v_s4, last_s4, v_s5, last_s5;
	logic [mmpc_pkg::RES_W-1:0]  col_s2, row_s2;
	logic [mmpc_pkg::PROD_W-1:0] prod_s3, prod_s4;
	logic [mmpc_pkg::RES_W-1:0]  q_s4;
	logic [mmpc_pkg::RES_W:0]    diff_s5;
	logic [mmpc_pkg::QP_W-1:0]   qp;
	logic [mmpc_pkg::PROD_W-1:0] qm;
	logic [mmpc_pkg::RES_W-1:0]  total_q, total_next;

	logic                        out_valid_q;
	logic [mmpc_pkg::RES_W-1:0]  checksum_q;

	// sizes above the store dimension saturate
	assign dim = (int'(matrix_size) > mmpc_pkg::MAX_DIM)
		? mmpc_pkg::DIM_W'(mmpc_pkg::MAX_DIM) : mmpc_pkg::DIM_W'(matrix_size);
	assign dim_m1 = mmpc_pkg::IDX_W'(dim - mmpc_pkg::DIM_W'(1));

	assign last_t     = (t_q == dim_m1);
	assign last_issue = last_t && (k_q == dim_m1);

	// A walked down column k, B along row k
	assign addr_a = mmpc_pkg::ADDR_W'(t_q) * mmpc_pkg::ADDR_W'(mmpc_pkg::MAX_DIM)
		+ mmpc_pkg::ADDR_W'(k_q);
	assign addr_b = mmpc_pkg::ADDR_W'(k_q) * mmpc_pkg::ADDR_W'(mmpc_pkg::MAX_DIM)
		+ mmpc_pkg::ADDR_W'(t_q);

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		we_a        = 1'b0;
		we_b        = 1'b0;
		walk_re     = 1'b0;
		start       = 1'b0;
		zero_result = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					case (head.op)
						mmpc_pkg::OP_LOAD_A: begin
							we_a = 1'b1;
							pop  = 1'b1;
						end
						mmpc_pkg::OP_LOAD_B: begin
							we_b = 1'b1;
							pop  = 1'b1;
						end
						mmpc_pkg::OP_COMPUTE: begin
							// compute waits until the result register is free
							if (!out_valid_q) begin
								pop = 1'b1;
								if (dim == '0) begin
									zero_result = 1'b1;
								end else begin
									start   = 1'b1;
									state_d = S_WALK;
								end
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			S_WALK: begin
				walk_re = 1'b1;
				if (last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (v_s5 && last_s5) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	mmpc_ram #(.WIDTH(mmpc_pkg::RES_W), .DEPTH(mmpc_pkg::MEM_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (head.addr),
		.wdata (head.value),
		.re    (walk_re),
		.raddr (addr_a),
		.rdata (a_rdata)
	);

	mmpc_ram #(.WIDTH(mmpc_pkg::RES_W), .DEPTH(mmpc_pkg::MEM_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (head.addr),
		.wdata (head.value),
		.re    (walk_re),
		.raddr (addr_b),
		.rdata (b_rdata)
	);

	assign col_next = mmpc_pkg::mod_add(rd_first_s1 ? '0 : col_acc_q, a_rdata);
	assign row_next = mmpc_pkg::mod_add(rd_first_s1 ? '0 : row_acc_q, b_rdata);

	always_comb begin
		qp = mmpc_pkg::QP_W'(prod_s3) * mmpc_pkg::QP_W'(mmpc_pkg::RECIP);
		qm = mmpc_pkg::PROD_W'(q_s4) * mmpc_pkg::PROD_W'(mmpc_pkg::MODULUS);
	end

	assign total_next = mmpc_pkg::mod_add(total_q, mmpc_pkg::reduce_once(diff_s5));

	// payload pipeline
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			col_acc_q <= col_next;
			row_acc_q <= row_next;
		end
		if (rd_v_s1 && rd_lastt_s1) begin
			col_s2 <= col_next;
			row_s2 <= row_next;
		end
		prod_s3 <= mmpc_pkg::PROD_W'(col_s2) * mmpc_pkg::PROD_W'(row_s2);
		prod_s4 <= prod_s3;
		q_s4    <= mmpc_pkg::RES_W'(qp >> mmpc_pkg::RECIP_SHIFT);
		diff_s5 <= (mmpc_pkg::RES_W + 1)'(prod_s4 - qm);
		if (start) begin
			total_q <= '0;
		end else if (v_s5) begin
			total_q <= total_next;
		end
		if (zero_result) begin
			checksum_q <= '0;
		end else if (v_s5 && last_s5) begin
			checksum_q <= total_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			t_q         <= '0;
			k_q         <= '0;
			rd_v_s1     <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_lastt_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			v_s3        <= 1'b0;
			last_s3     <= 1'b0;
			v_s4        <= 1'b0;
			last_s4     <= 1'b0;
			v_s5        <= 1'b0;
			last_s5     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				t_q <= '0;
				k_q <= '0;
			end else if (walk_re) begin
				if (last_t) begin
					t_q <= '0;
					k_q <= k_q + mmpc_pkg::IDX_W'(1);
				end else begin
					t_q <= t_q + mmpc_pkg::IDX_W'(1);
				end
			end
			rd_v_s1     <= walk_re;
			rd_first_s1 <= (t_q == '0);
			rd_lastt_s1 <= last_t;
			rd_last_s1  <= last_issue;
			v_s2        <= rd_v_s1 && rd_lastt_s1;
			last_s2     <= rd_v_s1 && rd_last_s1;
			v_s3        <= v_s2;
			last_s3     <= last_s2;
			v_s4        <= v_s3;
			last_s4     <= last_s3;
			v_s5        <= v_s4;
			last_s5     <= last_s4;
			if (zero_result || (v_s5 && last_s5)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("back end state not one-hot");

	a_walk_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !out_valid_q)
		else $error("result register busy during a compute walk");

	a_finish_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && last_s5 |-> state_q == S_DRAIN)
		else $error("final term outside drain");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !pop && !we_a && !we_b)
		else $error("queue served during a compute");

endmodule

// ----- rtl/core/modular_matrix_product_checksum.sv -----
// top level of the modular matrix product checksum block: size register, front end, back end
// depends on mmpc_pkg, mmpc_if, mmpc_front, mmpc_back (and mmpc_ram below it)
// Loads of A and B elements are taken one per cycle into a four-entry op queue while it has
// room, and the back end writes one element per cycle while no compute holds it. A compute
// transaction returns the sum of all entries of A*B modulo 997 as the sum over k of column k
// of A times row k of B; it holds the back end while it reads one element per cycle from each
// element ram over the N by N entries, N = min(size, 128), and then drains the product and
// reduction pipeline. A compute starts only once the previous checksum has been taken; loads
// behind it wait in the queue and new transactions are accepted while the queue has room.
// Size zero returns 0 from the cycle after the compute leaves the queue. The element stores
// are not cleared: every entry a compute covers must have been loaded first.
module modular_matrix_product_checksum (
	input  logic          clk,
	input  logic          arst_n,
	mmpc_item_if.sink     item,
	mmpc_result_if.source result,
	mmpc_cfg_if.sink      cfg
);

	logic [mmpc_pkg::SIZE_W-1:0] matrix_size_q;
	logic                        head_valid;
	mmpc_pkg::op_entry_t         head;
	logic                        pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= mmpc_pkg::SIZE_W'(mmpc_pkg::SIZE_RESET);
		end else if (cfg.valid) begin
			matrix_size_q <= cfg.matrix_size;
		end
	end

	mmpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	mmpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.matrix_size (matrix_size_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result      (result)
	);

endmodule
